// File: hw/rtl/aes_pkg.sv
// aes_pkg: shared types, constants and byte/column functions for the aes block cipher
// depends on nothing; used by aes_key_exp, aes_round and aes_block_cipher
package aes_pkg;

    localparam int RkDepth  = 60;
    localparam int RkWidth  = 32;
    localparam int BlockW   = 128;
    localparam int KeyWordW = 64;

    // configuration register indexes
    localparam logic [2:0] REG_KEY0     = 3'd0;
    localparam logic [2:0] REG_KEY1     = 3'd1;
    localparam logic [2:0] REG_KEY2     = 3'd2;
    localparam logic [2:0] REG_KEY3     = 3'd3;
    localparam logic [2:0] REG_KEY_SIZE = 3'd4;

    // key size codes
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    // command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;

    // start request from the top level to the round engine
    typedef struct packed {
        logic start;
        logic decrypt;
    } aes_cmd_t;

    localparam byte_t SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // multiply by x in the field
    function automatic byte_t xt(input byte_t a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // multiply by a 4-bit constant
    function automatic byte_t gmul(input byte_t a, input logic [3:0] b);
        byte_t acc;
        byte_t p;
        acc = 8'h00;
        p   = a;
        for (int k = 0; k < 4; k++)
        begin
            if (b[k])
                acc = acc ^ p;
            p = xt(p);
        end
        gmul = acc;
    endfunction

    // one column of mix, row 0 in the top byte
    function automatic word_t mix_col(input word_t c, input logic inv);
        byte_t a [4];
        byte_t o [4];
        logic [3:0] m [4];
        for (int k = 0; k < 4; k++)
            a[k] = c[31-8*k -: 8];
        if (inv)
        begin
            m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
        end
        else
        begin
            m[0] = 4'd2; m[1] = 4'd3; m[2] = 4'd1; m[3] = 4'd1;
        end
        for (int r = 0; r < 4; r++)
        begin
            o[r] = 8'h00;
            for (int k = 0; k < 4; k++)
                o[r] = o[r] ^ gmul(a[k], m[(k + 4 - r) % 4]);
        end
        mix_col = {o[0], o[1], o[2], o[3]};
    endfunction

    // forward substitution of each byte of a word
    function automatic word_t sub_word(input word_t w);
        sub_word = {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]],
                    SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
    endfunction

endpackage

// File: hw/rtl/aes_ram.sv
// aes_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module aes_ram #(
    parameter int Width = 32,
    parameter int Depth = 60
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/aes_key_exp.sv
// aes_key_exp: word-serial round key expansion, one key word written per cycle
// depends on aes_pkg; writes the round key memory
module aes_key_exp #(
    parameter int RkDepth = aes_pkg::RkDepth
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [63:0]                key [4],
    input  logic [1:0]                 key_size,
    output logic                       busy,
    output logic                       we,
    output logic [$clog2(RkDepth)-1:0] waddr,
    output aes_pkg::word_t             wdata
);

    localparam int AW = $clog2(RkDepth);

    logic           busy_reg, busy_next;
    logic [AW-1:0]  i_reg, i_next;
    logic [2:0]     j_reg, j_next;
    aes_pkg::byte_t rc_reg, rc_next;
    aes_pkg::word_t win_reg [8];
    aes_pkg::word_t w;
    aes_pkg::word_t t;
    logic [3:0]     nk;
    logic [AW-1:0]  total;
    logic           in_key;

    // words in key and total words
    always_comb
    begin
        case (key_size)
            aes_pkg::KS_128: nk = 4'd4;
            aes_pkg::KS_192: nk = 4'd6;
            default:         nk = 4'd8;
        endcase
        total = AW'(4 * (nk + 4'd7));
    end

    // next key word
    always_comb
    begin
        in_key = ({2'b00, i_reg} < (AW + 2)'(nk));
        t = win_reg[0];
        if (j_reg == 3'd0)
            t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_reg, 24'h0};
        else if (nk == 4'd8 && j_reg == 3'd4)
            t = aes_pkg::sub_word(t);
        if (in_key)
            w = i_reg[0] ? key[i_reg[2:1]][31:0] : key[i_reg[2:1]][63:32];
        else
            w = win_reg[3'(nk - 4'd1)] ^ t;
    end

    // counters and round constant
    always_comb
    begin
        busy_next = busy_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        rc_next   = rc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            i_next    = '0;
            j_next    = '0;
            rc_next   = 8'h01;
        end
        else if (busy_reg)
        begin
            i_next = i_reg + AW'(1);
            j_next = ({1'b0, j_reg} == nk - 4'd1) ? 3'd0 : j_reg + 3'd1;
            if (!in_key && j_reg == 3'd0)
                rc_next = aes_pkg::xt(rc_reg);
            if (i_reg == total - AW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            rc_reg   <= 8'h01;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            rc_reg   <= rc_next;
        end
    end

    // window of the last eight words, newest first
    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            win_reg[0] <= w;
            for (int k = 1; k < 8; k++)
                win_reg[k] <= win_reg[k-1];
        end
    end

    assign busy  = busy_reg;
    assign we    = busy_reg && !start;
    assign waddr = i_reg;
    assign wdata = w;

endmodule

// File: hw/rtl/aes_round.sv
// aes_round: byte/column-serial round engine, state in a 16-byte shift register
// depends on aes_pkg; reads round keys from the round key memory
module aes_round #(
    parameter int RkDepth = aes_pkg::RkDepth
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  aes_pkg::aes_cmd_t          cmd,
    input  logic [127:0]               data_in,
    input  logic [3:0]                 nr,
    output logic [$clog2(RkDepth)-1:0] raddr,
    input  aes_pkg::word_t             rdata,
    output logic                       busy,
    output logic                       done_valid,
    input  logic                       done_ready,
    output logic [127:0]               result
);

    localparam int AW = $clog2(RkDepth);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_SUB,
        ST_SHIFT,
        ST_MIX,
        ST_DONE
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [3:0]     rnd_reg, rnd_next;
    logic           dec_reg, dec_next;
    aes_pkg::byte_t s_reg [16];
    aes_pkg::byte_t s_next [16];
    aes_pkg::word_t col0;
    aes_pkg::word_t colx;

    assign col0  = {s_reg[0], s_reg[1], s_reg[2], s_reg[3]};
    assign raddr = AW'({rnd_reg, cnt_reg[1:0]});

    // state datapath and sequencer
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        dec_next   = dec_reg;
        s_next     = s_reg;
        colx       = aes_pkg::mix_col(col0, dec_reg);
        case (phase_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    dec_next   = cmd.decrypt;
                    rnd_next   = (cmd.decrypt == aes_pkg::CMD_DECRYPT) ? nr : 4'd0;
                    cnt_next   = '0;
                    phase_next = ST_KEY;
                    for (int k = 0; k < 16; k++)
                        s_next[k] = data_in[127-8*k -: 8];
                end
            end
            ST_KEY:
            begin
                // column rotation, key word arrives in the cycle after its address
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg != 4'd0)
                begin
                    colx = col0 ^ rdata;
                    for (int k = 0; k < 12; k++)
                        s_next[k] = s_reg[k+4];
                    for (int k = 0; k < 4; k++)
                        s_next[12+k] = colx[31-8*k -: 8];
                end
                if (cnt_reg == 4'd4)
                begin
                    cnt_next = '0;
                    if (!dec_reg)
                    begin
                        if (rnd_reg == nr)
                            phase_next = ST_DONE;
                        else
                        begin
                            rnd_next   = rnd_reg + 4'd1;
                            phase_next = ST_SUB;
                        end
                    end
                    else
                    begin
                        if (rnd_reg == 4'd0)
                            phase_next = ST_DONE;
                        else if (rnd_reg == nr)
                        begin
                            rnd_next   = rnd_reg - 4'd1;
                            phase_next = ST_SUB;
                        end
                        else
                            phase_next = ST_MIX;
                    end
                end
            end
            ST_SUB:
            begin
                // one byte through the substitution table per cycle
                for (int k = 0; k < 15; k++)
                    s_next[k] = s_reg[k+1];
                s_next[15] = dec_reg ? aes_pkg::SBOX_INV[s_reg[0]] : aes_pkg::SBOX_FWD[s_reg[0]];
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    cnt_next   = '0;
                    phase_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        s_next[4*c+r] = dec_reg ? s_reg[4*((c+4-r)%4)+r] : s_reg[4*((c+r)%4)+r];
                if (!dec_reg && rnd_reg != nr)
                    phase_next = ST_MIX;
                else
                    phase_next = ST_KEY;
            end
            ST_MIX:
            begin
                // one column per cycle
                for (int k = 0; k < 12; k++)
                    s_next[k] = s_reg[k+4];
                for (int k = 0; k < 4; k++)
                    s_next[12+k] = colx[31-8*k -: 8];
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3)
                begin
                    cnt_next = '0;
                    if (dec_reg)
                    begin
                        rnd_next   = rnd_reg - 4'd1;
                        phase_next = ST_SUB;
                    end
                    else
                        phase_next = ST_KEY;
                end
            end
            ST_DONE:
            begin
                if (done_ready)
                    phase_next = ST_IDLE;
            end
            default:
                phase_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            dec_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            dec_reg   <= dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    // result packing, byte 0 on top
    always_comb
    begin
        for (int k = 0; k < 16; k++)
            result[127-8*k -: 8] = s_reg[k];
    end

    assign busy       = (phase_reg != ST_IDLE);
    assign done_valid = (phase_reg == ST_DONE);

endmodule

// File: hw/rtl/aes_block_cipher.sv
// aes_block_cipher: top level, key registers, output register and assertions
// depends on aes_pkg, aes_ram, aes_key_exp and aes_round
//
// channel   | direction | request fields
// s_*       | in        | tuser[0]=command, tdata[63:0]=data_hi, tdata[127:64]=data_lo
// m_*       | out       | tdata[63:0]=result_hi, tdata[127:64]=result_lo
// cfg_*     | in        | cfg_index=register index, cfg_data=value
//
// an item holds the round engine (nr = 10, 12 or 14) from acceptance until its result is in
// the output register: a key add, then each middle round (bytewise substitution through
// one table, a row shift, a mix and a key add, the key add before the mix when decrypting),
// the last round with no mix, and the result handover; the engine returns to idle before
// the next request; a key write starts an expansion of 4*(nk+7) key words, one key word per
// cycle; no request is taken meanwhile, and key writes wait while an item is in the engine
// reset clears control state, round keys stay undefined until written
// a finished result waits in the output register while the next request is taken
module aes_block_cipher #(
    parameter int RkDepth = aes_pkg::RkDepth
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // data_hi, data_lo
    input  logic         s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_hi, result_lo
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int AW = $clog2(RkDepth);

    logic [63:0]       key_reg [4];
    logic [1:0]        key_size_reg;
    logic              kexp_start;
    logic              kexp_busy;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    aes_pkg::word_t    ram_wdata;
    logic [AW-1:0]     ram_raddr;
    aes_pkg::word_t    ram_rdata;
    aes_pkg::aes_cmd_t cmd;
    logic              core_busy;
    logic              done_valid;
    logic              done_ready;
    logic [127:0]      core_result;
    logic [3:0]        nr;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [127:0]      m_tdata_reg;
    logic              cfg_write;

    // configuration writes
    assign cfg_ready  = !kexp_busy && !core_busy;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign kexp_start = cfg_write && (cfg_index inside {[aes_pkg::REG_KEY0:aes_pkg::REG_KEY_SIZE]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                key_reg[k] <= '0;
            key_size_reg <= aes_pkg::KS_128;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY0:     key_reg[0]   <= cfg_data;
                aes_pkg::REG_KEY1:     key_reg[1]   <= cfg_data;
                aes_pkg::REG_KEY2:     key_reg[2]   <= cfg_data;
                aes_pkg::REG_KEY3:     key_reg[3]   <= cfg_data;
                aes_pkg::REG_KEY_SIZE: key_size_reg <= cfg_data[1:0];
                default:               ;
            endcase
        end
    end

    // rounds for the key size
    always_comb
    begin
        case (key_size_reg)
            aes_pkg::KS_128: nr = 4'd10;
            aes_pkg::KS_192: nr = 4'd12;
            default:         nr = 4'd14;
        endcase
    end

    aes_key_exp #(.RkDepth(RkDepth)) u_key_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (kexp_start),
        .key      (key_reg),
        .key_size (key_size_reg),
        .busy     (kexp_busy),
        .we       (ram_we),
        .waddr    (ram_waddr),
        .wdata    (ram_wdata)
    );

    aes_ram #(.Width(aes_pkg::RkWidth), .Depth(RkDepth)) u_rk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // input side
    assign s_tready = !core_busy && !kexp_busy && !kexp_start;
    assign cmd      = '{start: s_tvalid && s_tready, decrypt: s_tuser};

    aes_round #(.RkDepth(RkDepth)) u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_in    ({s_tdata[63:0], s_tdata[127:64]}),
        .nr         (nr),
        .raddr      (ram_raddr),
        .rdata      (ram_rdata),
        .busy       (core_busy),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .result     (core_result)
    );

    // output register
    assign done_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
            m_tvalid_next = 1'b0;
        if (done_valid && done_ready)
            m_tvalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_ready)
            m_tdata_reg <= {core_result[63:0], core_result[127:64]};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // no request taken while round keys are being rebuilt
    a_no_req_in_expand: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !kexp_busy)
        else $error("request taken during key expansion");

    // a valid key write starts an expansion
    a_write_expands: assert property (@(posedge clk) disable iff (!rst_n)
        kexp_start |=> kexp_busy)
        else $error("key write did not start expansion");

    // a result only moves into a free or draining output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (done_valid && done_ready) |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten");

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking testbench for aes_block_cipher (aes ecb, 128/192/256-bit keys)
// depends on aes_pkg and the aes_block_cipher rtl; holds its own cipher predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom = 550;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // data_hi, data_lo
    logic         s_tuser;   // command
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // result_hi, result_lo
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;

    aes_block_cipher dut (.*);

    typedef struct packed {
        logic        cmd;
        logic [63:0] hi;
        logic [63:0] lo;
    } block_req_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_res_t;

    // predictor state
    logic [63:0]    key_regs [4];
    logic [1:0]     key_len;
    logic [31:0]    sched [aes_pkg::RkDepth];
    aes_pkg::byte_t fwd_tab [256];
    aes_pkg::byte_t inv_tab [256];

    block_req_t  pending_blocks [$];
    block_res_t  expected_blocks [$];
    int          errors;
    int          results_seen;
    int          enc_seen;
    int          dec_seen;
    int          hold_off;
    logic        stall_mode;
    logic        cfg_busy;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // time limit
    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // sbox tables: forward from the field inverse plus affine map, inverse by lookup
    function automatic aes_pkg::byte_t gf_times(input aes_pkg::byte_t a,
                                                input aes_pkg::byte_t b);
        aes_pkg::byte_t acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc = acc ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic void build_tables();
        aes_pkg::byte_t inv_x;
        aes_pkg::byte_t s;
        for (int x = 0; x < 256; x++)
        begin
            inv_x = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_times(aes_pkg::byte_t'(x), aes_pkg::byte_t'(y)) == 8'h01)
                    inv_x = aes_pkg::byte_t'(y);
            s = inv_x ^ {inv_x[6:0], inv_x[7]} ^ {inv_x[5:0], inv_x[7:6]}
                ^ {inv_x[4:0], inv_x[7:5]} ^ {inv_x[3:0], inv_x[7:4]} ^ 8'h63;
            fwd_tab[x] = s;
            inv_tab[s] = aes_pkg::byte_t'(x);
        end
    endfunction

    function automatic int key_words();
        return (key_len == aes_pkg::KS_128) ? 4 : (key_len == aes_pkg::KS_192) ? 6 : 8;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
    endfunction

    // key schedule
    function automatic void expand_schedule();
        int             nk;
        logic [31:0]    t;
        aes_pkg::byte_t rc;
        nk = key_words();
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_regs[i/2][31:0] : key_regs[i/2][63:32];
        for (int i = nk; i < 4 * (nk + 7); i++)
        begin
            t = sched[i-1];
            if (i % nk == 0)
            begin
                t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_times(rc, 8'h02);
            end
            else if (nk == 8 && i % nk == 4)
                t = subst_word(t);
            sched[i] = sched[i-nk] ^ t;
        end
    endfunction

    function automatic void add_round_key(ref aes_pkg::byte_t st [16], input int r);
        for (int c = 0; c < 4; c++)
            for (int b = 0; b < 4; b++)
                st[4*c+b] ^= sched[(4*r+c) % aes_pkg::RkDepth][31-8*b -: 8];
    endfunction

    function automatic void subst_rows(ref aes_pkg::byte_t st [16], input logic inv);
        aes_pkg::byte_t t [16];
        int             src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                t[4*c+r] = inv ? inv_tab[st[4*src+r]] : fwd_tab[st[4*src+r]];
            end
        st = t;
    endfunction

    function automatic void mix_columns(ref aes_pkg::byte_t st [16], input logic inv);
        aes_pkg::byte_t m [4];
        aes_pkg::byte_t col [4];
        aes_pkg::byte_t acc;
        if (inv)
            m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
                col[k] = st[4*c+k];
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_times(col[k], m[(k + 4 - r) % 4]);
                st[4*c+r] = acc;
            end
        end
    endfunction

    // expected cipher output for one block
    function automatic block_res_t cipher_block(input block_req_t rq);
        aes_pkg::byte_t st [16];
        int             nr;
        block_res_t     rs;
        nr = key_words() + 6;
        for (int i = 0; i < 8; i++)
        begin
            st[i]   = rq.hi[63-8*i -: 8];
            st[8+i] = rq.lo[63-8*i -: 8];
        end
        if (rq.cmd == aes_pkg::CMD_ENCRYPT)
        begin
            add_round_key(st, 0);
            for (int r = 1; r < nr; r++)
            begin
                subst_rows(st, 1'b0);
                mix_columns(st, 1'b0);
                add_round_key(st, r);
            end
            subst_rows(st, 1'b0);
            add_round_key(st, nr);
        end
        else
        begin
            add_round_key(st, nr);
            for (int r = nr - 1; r >= 1; r--)
            begin
                subst_rows(st, 1'b1);
                add_round_key(st, r);
                mix_columns(st, 1'b1);
            end
            subst_rows(st, 1'b1);
            add_round_key(st, 0);
        end
        for (int i = 0; i < 8; i++)
        begin
            rs.hi[63-8*i -: 8] = st[i];
            rs.lo[63-8*i -: 8] = st[8+i];
        end
        return rs;
    endfunction

    // block request driver
    int src_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            src_gap  <= 0;
        end
        else
        begin
            block_req_t nxt;
            int         gap;
            if (s_tvalid && s_tready)
            begin
                expected_blocks.push_back(cipher_block({s_tuser, s_tdata[63:0], s_tdata[127:64]}));
                if (s_tuser == aes_pkg::CMD_DECRYPT)
                    dec_seen = dec_seen + 1;
                else
                    enc_seen = enc_seen + 1;
                void'(pending_blocks.pop_front());
                gap = stall_mode ? 0 : $urandom_range(0, 4);
                if (pending_blocks.size() > 0 && gap == 0)
                begin
                    // next request right behind the accepted one
                    nxt = pending_blocks[0];
                    s_tdata <= {nxt.lo, nxt.hi};
                    s_tuser <= nxt.cmd;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    src_gap  <= (gap > 0) ? gap - 1 : 0;
                end
            end
            else if (!s_tvalid && !cfg_busy && pending_blocks.size() > 0)
            begin
                if (src_gap > 0)
                    src_gap <= src_gap - 1;
                else
                begin
                    nxt = pending_blocks[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.lo, nxt.hi};
                    s_tuser  <= nxt.cmd;
                end
            end
        end
    end

    // result monitor with random and long receiver stalls
    int sink_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
            hold_off <= 0;
        end
        else
        begin
            block_res_t want;
            if (m_tvalid && m_tready)
            begin
                results_seen = results_seen + 1;
                if (expected_blocks.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (m_tdata[63:0] !== want.hi)
                    begin
                        $error("result_hi expected %h actual %h", want.hi, m_tdata[63:0]);
                        errors = errors + 1;
                    end
                    if (m_tdata[127:64] !== want.lo)
                    begin
                        $error("result_lo expected %h actual %h", want.lo, m_tdata[127:64]);
                        errors = errors + 1;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end
            else if (m_tvalid && m_tready || !m_tready)
            begin
                if (m_tvalid && m_tready)
                begin
                    sink_gap <= $urandom_range(0, 4);
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                else if (sink_gap > 0)
                    sink_gap <= sink_gap - 1;
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // register write, only while idle; valid stays up until the key load ends
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_busy  <= 1'b1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            aes_pkg::REG_KEY0, aes_pkg::REG_KEY1, aes_pkg::REG_KEY2, aes_pkg::REG_KEY3:
                key_regs[idx[1:0]] = val;
            aes_pkg::REG_KEY_SIZE: key_len = val[1:0];
            default: ;
        endcase
        expand_schedule();
    endtask

    task automatic load_key(input logic [63:0] k0, k1, k2, k3, input logic [1:0] ks);
        write_reg(aes_pkg::REG_KEY0, k0);
        write_reg(aes_pkg::REG_KEY1, k1);
        write_reg(aes_pkg::REG_KEY2, k2);
        write_reg(aes_pkg::REG_KEY3, k3);
        write_reg(aes_pkg::REG_KEY_SIZE, {62'd0, ks});
        cfg_valid <= 1'b0;
        cfg_busy  <= 1'b0;
    endtask

    // wait until every queued block is answered, then let the engine settle
    task automatic drain();
        while (pending_blocks.size() > 0 || expected_blocks.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_block(input logic cmd, input logic [63:0] hi, lo);
        pending_blocks.push_back('{cmd: cmd, hi: hi, lo: lo});
    endtask

    // stimulus
    initial
    begin
        logic [1:0] ks;
        int         kind;
        errors = 0; results_seen = 0; enc_seen = 0; dec_seen = 0;
        stall_mode = 1'b0;
        cfg_busy   = 1'b1;
        cfg_valid  = 1'b0;
        cfg_index  = aes_pkg::REG_KEY0;
        cfg_data   = '0;
        key_len    = aes_pkg::KS_128;
        key_regs   = '{default: '0};
        build_tables();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: standard vectors, 128-bit key, plus field extremes
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                 64'h18191a1b1c1d1e1f, aes_pkg::KS_128);
        push_block(aes_pkg::CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        push_block(aes_pkg::CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        push_block(aes_pkg::CMD_ENCRYPT, '0, '0);
        push_block(aes_pkg::CMD_DECRYPT, '1, '1);
        push_block(aes_pkg::CMD_ENCRYPT, '1, '0);
        drain();
        // 192-bit key
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                 '1, aes_pkg::KS_192);
        push_block(aes_pkg::CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        push_block(aes_pkg::CMD_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        push_block(aes_pkg::CMD_DECRYPT, '0, '1);
        drain();
        // 256-bit key, key size three, all-ones key, all-zero key
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                 64'h18191a1b1c1d1e1f, 2'd2);
        push_block(aes_pkg::CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        push_block(aes_pkg::CMD_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        drain();
        load_key('1, '1, '1, '1, 2'd3);
        push_block(aes_pkg::CMD_ENCRYPT, '1, '1);
        push_block(aes_pkg::CMD_DECRYPT, '0, '0);
        drain();
        load_key('0, '0, '0, '0, aes_pkg::KS_128);
        push_block(aes_pkg::CMD_ENCRYPT, '0, '0);
        push_block(aes_pkg::CMD_DECRYPT, '1, '1);
        drain();

        // random phases: random keys, each of a random size
        for (int ph = 0; ph < 11; ph++)
        begin
            ks = 2'($urandom_range(0, 3));
            load_key(rand64(), rand64(), rand64(), rand64(), ks);
            // one phase with a long receiver stall while blocks keep coming
            if (ph == 3)
            begin
                stall_mode = 1'b1;
                hold_off   = 600;
            end
            for (int i = 0; i < NumRandom / 11; i++)
            begin
                kind = $urandom_range(0, 9);
                push_block(logic'($urandom_range(0, 1)),
                           kind == 0 ? 64'h0 : kind == 1 ? '1 : rand64(),
                           kind == 2 ? 64'h0 : kind == 3 ? '1 : rand64());
            end
            drain();
            stall_mode = 1'b0;
        end

        $display("ran %0d blocks (%0d encrypt, %0d decrypt) under 128, 192 and 256-bit keys",
                 results_seen, enc_seen, dec_seen);
        $display("including a long output stall and random idles on both channels");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
